[sv/tmc_pkg.sv]
// ============================================================================
// tmc_pkg
// Types, constants and codes shared by the manifest checker modules.
// ============================================================================
package tmc_pkg;

    localparam int          MAX_ENTRIES_DEF   = 4;
    localparam logic [31:0] MANIFEST_MAGIC    = 32'h3158_4253;
    localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd4096;
    localparam logic [31:0] RES_ID_LOW_RST    = 32'h0005_0000;
    localparam logic [31:0] RES_ID_HIGH_RST   = 32'h0005_0009;
    localparam logic [3:0]  HEADER_LEN        = 4'd8;
    localparam logic [4:0]  ENTRY_LEN         = 5'd24;
    localparam logic [8:0]  POS_MAX           = 9'd511;
    localparam int          QUEUE_DEPTH       = 4;

    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_LENGTH = 2'd1;
    localparam logic [1:0] VERDICT_FIELD  = 2'd2;
    localparam logic [1:0] VERDICT_DUP    = 2'd3;

    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_ID_LOW      = 2'd1;
    localparam logic [1:0] REG_ID_HIGH     = 2'd2;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic [7:0]  stage_no;
        logic [15:0] tgt_type;
        logic [15:0] tgt_major;
        logic [15:0] tgt_minor;
        logic [31:0] slot_id_a;
        logic [31:0] slot_id_b;
        logic [15:0] blob_size;
        logic [31:0] blob_crc;
        logic [1:0]  verdict;
        logic [4:0]  entry_count;
    } out_t;

    typedef struct packed {
        logic [7:0]  stage;
        logic [31:0] slot_a;
        logic [31:0] slot_b;
    } key_t;

endpackage

[sv/tmc_cell.sv]
// ============================================================================
// tmc_cell
// One stored entry key: shifts to its neighbor and flags a key collision.
// ============================================================================
module tmc_cell (
    input  logic          aclk,
    input  logic          shift_en,
    input  tmc_pkg::key_t key_i,
    input  tmc_pkg::key_t probe_i,
    output tmc_pkg::key_t key_o,
    output logic          hit_o
);
    import tmc_pkg::*;

    key_t key_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg <= key_i;
        end
    end

    assign key_o = key_reg;
    assign hit_o = (probe_i.stage == key_reg.stage) ||
                   (probe_i.slot_a == key_reg.slot_a) ||
                   (probe_i.slot_a == key_reg.slot_b) ||
                   (probe_i.slot_b == key_reg.slot_a) ||
                   (probe_i.slot_b == key_reg.slot_b);
endmodule

[sv/tmc_queue.sv]
// ============================================================================
// tmc_queue
// Result queue that takes up to two beats a cycle and drives the m_ channel.
// ============================================================================
module tmc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_a,
    input  logic          push_b,
    input  tmc_pkg::out_t data_a,
    input  tmc_pkg::out_t data_b,
    output logic          room,
    output logic          m_valid,
    input  logic          m_ready,
    output tmc_pkg::out_t m_data
);
    import tmc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    out_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    assign room    = (count_reg <= (PW+1)'(QUEUE_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push_a) + PW'(push_b);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + (PW+1)'(push_a) + (PW+1)'(push_b) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_a) begin
            mem[wr_ptr_reg] <= data_a;
        end
        if (push_b) begin
            mem[wr_ptr_reg + PW'(1)] <= data_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

[sv/transaction_manifest_checker_unit.sv]
// ============================================================================
// transaction_manifest_checker_unit
// Streaming checker for commit-manifest records, one byte per beat.
// ============================================================================
// Takes one record byte per cycle while s_ready is high. Each entry that
// passes its checks comes out on its 24th byte, and the final byte brings a
// verdict beat; the results go through a four-beat queue, and s_ready drops
// only when that queue lacks room for two beats. Keys of accepted entries
// sit in a shift chain of MAX_ENTRIES cells that compare a new entry against
// every stored key in the cycle its last byte arrives.
module transaction_manifest_checker_unit #(
    parameter int MAX_ENTRIES = tmc_pkg::MAX_ENTRIES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tmc_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tmc_pkg::out_t m_data,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_wdata
);
    import tmc_pkg::*;

    logic [15:0]  max_payload_reg;
    logic [31:0]  id_low_reg, id_high_reg;
    logic [8:0]   pos_reg, pos_next;
    logic [63:0]  hdr_reg, hdr_next, hdr_wr, hdr_cur;
    logic [4:0]   ecnt_reg, ecnt_next;
    logic [191:0] asm_reg, asm_next, asm_wr;
    logic [4:0]   done_reg, done_next;
    logic [1:0]   err_reg, err_next, err_fin;

    logic        accept, shift_en, push_a, push_b, room;
    out_t        out_a, out_b, ent_out, ver_out;
    logic [12:0] expected;
    logic [8:0]  pos_inc;
    logic        hdr_err, field_err, dup;
    key_t        probe;
    key_t        chain [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] hit;
    logic [MAX_ENTRIES-1:0] cell_valid;

    assign accept  = s_valid && s_ready;
    assign s_ready = room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            id_low_reg      <= RES_ID_LOW_RST;
            id_high_reg     <= RES_ID_HIGH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_wdata[15:0];
                REG_ID_LOW:      id_low_reg      <= cfg_wdata;
                REG_ID_HIGH:     id_high_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        hdr_wr = hdr_reg;
        hdr_wr[{pos_reg[2:0], 3'b000} +: 8] = s_data.data_byte;
        asm_wr = asm_reg;
        asm_wr[{ecnt_reg, 3'b000} +: 8] = s_data.data_byte;
        hdr_cur = (err_reg == VERDICT_OK && pos_reg < 9'(HEADER_LEN)) ? hdr_wr : hdr_reg;
        expected = 13'(HEADER_LEN) + 13'(ENTRY_LEN) * 13'(hdr_cur[47:40]);
        pos_inc  = (pos_reg < POS_MAX) ? pos_reg + 9'd1 : pos_reg;
    end

    always_comb begin
        hdr_err = (hdr_wr[31:0] != MANIFEST_MAGIC) || (hdr_wr[63:48] != 16'd0) ||
                  (hdr_wr[39:32] > 8'd1) || (hdr_wr[47:40] > 8'(MAX_ENTRIES)) ||
                  (hdr_wr[39:32] == 8'd0 && hdr_wr[47:40] != 8'd0) ||
                  (hdr_wr[39:32] == 8'd1 && hdr_wr[47:40] == 8'd0);
    end

    always_comb begin
        probe.stage  = asm_wr[7:0];
        probe.slot_a = asm_wr[95:64];
        probe.slot_b = asm_wr[127:96];
        field_err = (asm_wr[15:8] != 8'd0) || (asm_wr[159:144] != 16'd0) ||
                    (probe.stage >= 8'(MAX_ENTRIES)) || (asm_wr[31:16] == 16'd0) ||
                    (asm_wr[47:32] == 16'd0) || (asm_wr[143:128] > max_payload_reg) ||
                    (probe.slot_a == probe.slot_b) ||
                    (probe.slot_a >= id_low_reg && probe.slot_a <= id_high_reg) ||
                    (probe.slot_b >= id_low_reg && probe.slot_b <= id_high_reg);
        dup = |(hit & cell_valid);
    end

    assign chain[0] = probe;
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        assign cell_valid[k] = (5'(k) < done_reg);
        tmc_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .key_i    (chain[k]),
            .probe_i  (probe),
            .key_o    (chain[k+1]),
            .hit_o    (hit[k])
        );
    end

    always_comb begin
        ent_out             = '0;
        ent_out.kind        = KIND_ENTRY;
        ent_out.last        = !s_data.final_byte;
        ent_out.stage_no    = probe.stage;
        ent_out.tgt_type    = asm_wr[31:16];
        ent_out.tgt_major   = asm_wr[47:32];
        ent_out.tgt_minor   = asm_wr[63:48];
        ent_out.slot_id_a   = probe.slot_a;
        ent_out.slot_id_b   = probe.slot_b;
        ent_out.blob_size   = asm_wr[143:128];
        ent_out.blob_crc    = asm_wr[191:160];
    end

    always_comb begin
        hdr_next  = hdr_reg;
        asm_next  = asm_reg;
        ecnt_next = ecnt_reg;
        pos_next  = pos_reg;
        done_next = done_reg;
        err_next  = err_reg;
        err_fin   = err_reg;
        shift_en  = 1'b0;
        push_a    = 1'b0;
        push_b    = 1'b0;
        out_a     = ent_out;
        out_b     = '0;
        ver_out   = '0;
        if (accept) begin
            if (err_reg == VERDICT_OK) begin
                if (pos_reg < 9'(HEADER_LEN)) begin
                    hdr_next = hdr_wr;
                    if (pos_reg == 9'(HEADER_LEN) - 9'd1) begin
                        err_next = hdr_err ? VERDICT_LENGTH : VERDICT_OK;
                    end
                end else if (13'(pos_reg) >= expected) begin
                    err_next = VERDICT_LENGTH;
                end else begin
                    asm_next = asm_wr;
                    if (ecnt_reg == ENTRY_LEN - 5'd1) begin
                        ecnt_next = '0;
                        asm_next  = '0;
                        priority if (field_err) begin
                            err_next = VERDICT_FIELD;
                        end else if (dup) begin
                            err_next = VERDICT_DUP;
                        end else if (done_reg >= 5'(MAX_ENTRIES)) begin
                            err_next = VERDICT_LENGTH;
                        end else begin
                            shift_en  = 1'b1;
                            done_next = done_reg + 5'd1;
                            push_a    = 1'b1;
                        end
                    end else begin
                        ecnt_next = ecnt_reg + 5'd1;
                    end
                end
            end
            pos_next = pos_inc;
            if (s_data.final_byte) begin
                err_fin = err_next;
                if (pos_inc < 9'(HEADER_LEN)) begin
                    err_fin = VERDICT_LENGTH;
                end else if (err_next != VERDICT_LENGTH && 13'(pos_inc) != expected) begin
                    err_fin = VERDICT_LENGTH;
                end
                ver_out.kind        = KIND_VERDICT;
                ver_out.last        = 1'b1;
                ver_out.verdict     = err_fin;
                ver_out.entry_count = (err_fin == VERDICT_OK) ? hdr_cur[44:40] : 5'd0;
                if (push_a) begin
                    push_b = 1'b1;
                    out_b  = ver_out;
                end else begin
                    push_a = 1'b1;
                    out_a  = ver_out;
                end
                pos_next  = '0;
                hdr_next  = '0;
                ecnt_next = '0;
                asm_next  = '0;
                done_next = '0;
                err_next  = VERDICT_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            hdr_reg  <= '0;
            ecnt_reg <= '0;
            asm_reg  <= '0;
            done_reg <= '0;
            err_reg  <= VERDICT_OK;
        end else begin
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            ecnt_reg <= ecnt_next;
            asm_reg  <= asm_next;
            done_reg <= done_next;
            err_reg  <= err_next;
        end
    end

    tmc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_a  (push_a),
        .push_b  (push_b),
        .data_a  (out_a),
        .data_b  (out_b),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push_b |-> push_a && out_a.kind == KIND_ENTRY && out_b.kind == KIND_VERDICT)
        else $error("second result beat without an entry beat ahead of it");

    a_done_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg <= 5'(MAX_ENTRIES))
        else $error("accepted entry count beyond the cell chain");

    a_entry_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_a && out_a.kind == KIND_ENTRY) |-> err_reg == VERDICT_OK && !dup)
        else $error("entry beat pushed after an error");

    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ecnt_reg < ENTRY_LEN)
        else $error("entry byte offset out of range");
endmodule
